// ===== rtl/vbc_pkg.sv =====
// vbc_pkg: shared types, constants and command/status structs for the
// value banding classifier. no dependencies.
package vbc_pkg;

    localparam int VALUE_W   = 32;
    localparam int BAND_W    = 16;
    localparam int MAX_BND   = 16;
    localparam int IDX_W     = 4;
    localparam int PCNT_W    = 5;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 3'd5;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_COUNT  = 2'd1;
    localparam logic [1:0] MODE_POINTS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_SCAN,
        S_DONE
    } vbc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word and decode
        logic div_step; // one quotient bit
        logic scan_step;// one table entry
        logic finish;   // form result
    } vbc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic need_scan;
        logic div_last;
        logic scan_last;
    } vbc_stat_t;

endpackage

// ===== rtl/vbc_ctrl.sv =====
// vbc_ctrl: sequencing state machine of the value banding classifier.
// depends on vbc_pkg.
module vbc_ctrl
    import vbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_busy,
    input  vbc_stat_t stat,
    output vbc_cmd_t  cmd,
    output logic      busy
);

    vbc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                priority if (stat.need_div) state_next = S_DIV;
                else if (stat.need_scan)    state_next = S_SCAN;
                else                        state_next = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !out_busy)
        else $error("result over a held word");
    a_load_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_SETUP)
        else $error("load not followed by setup");

endmodule

// ===== rtl/vbc_dpath.sv =====
// vbc_dpath: config registers, boundary table, restoring divider and
// table scanner of the value banding classifier. depends on vbc_pkg.
module vbc_dpath
    import vbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_fire,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    input  logic                 in_opcode,
    input  logic [VALUE_W-1:0]   in_value,
    input  logic [IDX_W-1:0]     in_entry_index,
    input  vbc_cmd_t             cmd,
    output vbc_stat_t            stat,
    output logic [BAND_W-1:0]    band,
    output logic [1:0]           status
);

    localparam int DIVN_W = VALUE_W + CNT_W; // dividend width
    localparam int QCNT_W = $clog2(DIVN_W + 1);
    localparam int BMAX   = (1 << BAND_W) - 1;

    logic [1:0]          mode_reg;
    logic [VALUE_W-1:0]  start_reg, stop_reg, step_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PCNT_W-1:0]   pcnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_STEP;
            start_reg <= '0;
            stop_reg  <= '0;
            step_reg  <= '0;
            count_reg <= '0;
            pcnt_reg  <= PCNT_W'(2);
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_MODE:   mode_reg  <= cfg_data[1:0];
                REG_START:  start_reg <= cfg_data;
                REG_STOP:   stop_reg  <= cfg_data;
                REG_STEP:   step_reg  <= cfg_data;
                REG_COUNT:  count_reg <= cfg_data[CNT_W-1:0];
                REG_POINTS: pcnt_reg  <= cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // boundary table, one write and one read port
    logic [VALUE_W-1:0] table_mem [MAX_BND];

    // ---------------- decode at load ----------------
    logic signed [VALUE_W-1:0] v_s, st_s, sp_s, stp_s;
    assign v_s   = in_value;
    assign st_s  = start_reg;
    assign sp_s  = stop_reg;
    assign stp_s = step_reg;

    logic [VALUE_W-1:0] off_c, span_c, smag_c;
    logic [1:0]         d_status;
    logic               d_div, d_scan, d_cnt;

    always_comb begin
        off_c    = '0;
        span_c   = '0;
        smag_c   = '0;
        d_status = ST_OK;
        d_div    = 1'b0;
        d_scan   = 1'b0;
        d_cnt    = 1'b0;
        if (in_opcode == OP_CLASSIFY) begin
            unique case (mode_reg)
                MODE_STEP: begin
                    if (stp_s > 0) begin
                        if (st_s > sp_s) d_status = ST_INVALID;
                        else if (!(v_s < st_s || v_s > sp_s)) begin
                            off_c  = in_value - start_reg;
                            span_c = stop_reg - start_reg;
                            smag_c = step_reg;
                            d_div  = 1'b1;
                        end
                    end else if (stp_s < 0) begin
                        if (st_s < sp_s) d_status = ST_INVALID;
                        else if (!(v_s > st_s || v_s < sp_s)) begin
                            off_c  = start_reg - in_value;
                            span_c = start_reg - stop_reg;
                            smag_c = '0 - step_reg;
                            d_div  = 1'b1;
                        end
                    end else begin
                        d_status = ST_INVALID;
                    end
                end
                MODE_COUNT: begin
                    if (count_reg == '0 || st_s == sp_s) d_status = ST_INVALID;
                    else if (sp_s > st_s) begin
                        if (!(v_s < st_s || v_s > sp_s)) begin
                            off_c  = in_value - start_reg;
                            span_c = stop_reg - start_reg;
                            d_div  = 1'b1;
                            d_cnt  = 1'b1;
                        end
                    end else if (!(v_s > st_s || v_s < sp_s)) begin
                        off_c  = start_reg - in_value;
                        span_c = start_reg - stop_reg;
                        d_div  = 1'b1;
                        d_cnt  = 1'b1;
                    end
                end
                MODE_POINTS: begin
                    if (pcnt_reg < PCNT_W'(2)) d_status = ST_INVALID;
                    else d_scan = 1'b1;
                end
                default: d_status = ST_INVALID;
            endcase
        end
    end

    // ---------------- item registers ----------------
    logic                      cnt_reg;
    logic [1:0]                st_reg;
    logic                      div_reg, scan_reg;
    logic [VALUE_W-1:0]        span_reg;
    logic signed [VALUE_W-1:0] val_reg;
    // divider
    logic [DIVN_W-1:0]  rem_reg, quo_reg;   // rem holds partial remainder
    logic [DIVN_W-1:0]  dvd_reg;            // shifting dividend
    logic [DIVN_W-1:0]  dvs_reg;            // divisor
    logic [QCNT_W-1:0]  qcnt_reg;
    logic               pass_reg;           // step mode: 0 offset pass, 1 span pass
    logic [VALUE_W-1:0] q1_reg;             // floor(off/s)
    // scanner
    logic [IDX_W:0]     sidx_reg;
    logic [PCNT_W-1:0]  nuse_reg;
    logic signed [VALUE_W-1:0] prev_reg;
    logic               asc_reg, desc_reg;
    logic [BAND_W-1:0]  ahit_reg, dhit_reg;
    logic [VALUE_W-1:0] rd_reg;

    // multiply offset by count for count mode dividend
    logic [DIVN_W-1:0] prod_c;
    assign prod_c = DIVN_W'(off_c) * DIVN_W'(count_reg);

    // restoring divide step
    logic [DIVN_W:0]   trial_c;
    logic [DIVN_W-1:0] rem_sh_c;
    assign rem_sh_c = {rem_reg[DIVN_W-2:0], dvd_reg[DIVN_W-1]};
    assign trial_c  = {1'b0, rem_sh_c} - {1'b0, dvs_reg};

    logic [DIVN_W-1:0] quo_nx_c, rem_nx_c;
    assign quo_nx_c = {quo_reg[DIVN_W-2:0], ~trial_c[DIVN_W]};
    assign rem_nx_c = trial_c[DIVN_W] ? rem_sh_c : trial_c[DIVN_W-1:0];

    assign stat.need_div  = div_reg;
    assign stat.need_scan = scan_reg;
    assign stat.div_last  = (qcnt_reg == QCNT_W'(1)) && (cnt_reg || pass_reg);
    assign stat.scan_last = (sidx_reg == nuse_reg - PCNT_W'(1));

    logic [PCNT_W-1:0] nuse_c;
    assign nuse_c = (pcnt_reg > PCNT_W'(MAX_BND)) ? PCNT_W'(MAX_BND) : pcnt_reg;

    // scanner compares (entry sidx-1 in prev, entry sidx in rd)
    logic signed [VALUE_W-1:0] cur_s;
    logic top_c, ahit_c, dhit_c;
    assign cur_s  = rd_reg;
    assign top_c  = ({1'b0, sidx_reg} == {1'b0, nuse_reg} - (PCNT_W+1)'(1));
    assign ahit_c = (val_reg >= prev_reg) && (top_c ? val_reg <= cur_s : val_reg < cur_s);
    assign dhit_c = (val_reg <= prev_reg) && (top_c ? val_reg >= cur_s : val_reg > cur_s);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (in_opcode == OP_WRITE) table_mem[in_entry_index] <= in_value;
            st_reg   <= d_status;
            div_reg  <= d_div;
            scan_reg <= d_scan;
            cnt_reg  <= d_cnt;
            span_reg <= span_c;
            val_reg  <= in_value;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= d_cnt ? prod_c : DIVN_W'(off_c);
            dvs_reg  <= d_cnt ? DIVN_W'(span_c) : DIVN_W'(smag_c);
            qcnt_reg <= QCNT_W'(DIVN_W);
            pass_reg <= 1'b0;
            nuse_reg <= nuse_c;
            sidx_reg <= '0;
            asc_reg  <= 1'b1;
            desc_reg <= 1'b1;
            ahit_reg <= '0;
            dhit_reg <= '0;
            rd_reg   <= table_mem[0];
        end else if (cmd.div_step) begin
            if (qcnt_reg == QCNT_W'(1) && !cnt_reg && !pass_reg) begin
                // offset quotient done, restart on span for ceil(D/s)
                q1_reg   <= quo_nx_c[VALUE_W-1:0];
                pass_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dvd_reg  <= DIVN_W'(span_reg);
                qcnt_reg <= QCNT_W'(DIVN_W);
            end else begin
                rem_reg  <= rem_nx_c;
                quo_reg  <= quo_nx_c;
                dvd_reg  <= {dvd_reg[DIVN_W-2:0], 1'b0};
                qcnt_reg <= qcnt_reg - QCNT_W'(1);
            end
        end else if (cmd.scan_step) begin
            // sidx 0 only primes prev with entry 0
            prev_reg <= rd_reg;
            sidx_reg <= sidx_reg + (IDX_W+1)'(1);
            rd_reg   <= table_mem[IDX_W'(sidx_reg + (IDX_W+1)'(1))];
            if (sidx_reg != '0) begin
                asc_reg  <= asc_reg && (prev_reg <= cur_s);
                desc_reg <= desc_reg && (prev_reg >= cur_s);
                if (ahit_c) ahit_reg <= BAND_W'(sidx_reg);
                if (dhit_c) dhit_reg <= BAND_W'(sidx_reg);
            end
        end
    end

    // ---------------- result ----------------
    logic [DIVN_W:0] kmax_c, q_c, bnd_c;
    always_comb begin
        // step: kmax = ceil(D/s) at least 1, band = min(q, kmax-1)+1
        // count: band = min(q+1, c)
        kmax_c = {1'b0, quo_nx_c} + ((rem_nx_c != '0) ? (DIVN_W+1)'(1) : '0);
        if (kmax_c == '0) kmax_c = (DIVN_W+1)'(1);
        q_c = cnt_reg ? {1'b0, quo_nx_c} : (DIVN_W+1)'(q1_reg);
        if (cnt_reg) begin
            bnd_c = q_c + (DIVN_W+1)'(1);
            if (bnd_c > (DIVN_W+1)'(count_reg)) bnd_c = (DIVN_W+1)'(count_reg);
        end else begin
            bnd_c = ((q_c < kmax_c - (DIVN_W+1)'(1)) ? q_c : kmax_c - (DIVN_W+1)'(1))
                    + (DIVN_W+1)'(1);
        end
    end

    logic [DIVN_W:0]   bres_reg;
    always_ff @(posedge aclk) begin
        if (cmd.div_step && stat.div_last) begin
            bres_reg <= bnd_c;
        end else if (cmd.load) begin
            bres_reg <= '0;
        end
    end

    // status for scan mode is resolved at finish from asc/desc
    always_comb begin
        logic [DIVN_W:0] b;
        b      = bres_reg;
        status = st_reg;
        if (scan_reg) begin
            if (!asc_reg && !desc_reg) begin
                status = ST_INVALID;
                b      = '0;
            end else begin
                b = (DIVN_W+1)'(asc_reg ? ahit_reg : dhit_reg);
            end
        end
        if (status == ST_OK && b > (DIVN_W+1)'(BMAX)) begin
            band   = BAND_W'(BMAX);
            status = ST_SAT;
        end else begin
            band = b[BAND_W-1:0];
        end
    end

endmodule

// ===== rtl/value_banding_classifier.sv =====
// value_banding_classifier: top level, joins controller and datapath and
// holds the result word register. depends on vbc_pkg, vbc_ctrl, vbc_dpath.
//
// usage
//  - s_ channel carries one word per item: opcode, value, entry_index.
//    opcode write stores value into boundary entry entry_index and returns
//    a word with band 0, status ok.
//  - m_ channel returns exactly one word (band, status) per input word.
//  - cfg channel writes a register by index (mode, start, stop, step,
//    band count, point count); write only while no item is in flight.
// timing
//  - one item at a time; step and count modes run a 48-step restoring
//    divider (step mode runs it twice: offset and span); points mode
//    walks the boundary table one entry a cycle; writes and out-of-range
//    or invalid cases skip both the divider and the table walk.
//  - the result sits in an output register; a stalled m_ready holds it and
//    the next word is taken, computed, and waits for the register to free.
// reset
//  - aresetn low clears state, config and m_valid registers; the table
//    is not cleared and reads of unwritten entries are undefined.
module value_banding_classifier
    import vbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [VALUE_W-1:0]   s_value,
    input  logic [IDX_W-1:0]     s_entry_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BAND_W-1:0]    m_band,
    output logic [1:0]           m_status
);

    vbc_cmd_t  cmd;
    vbc_stat_t stat;
    logic      busy;
    logic      in_fire;
    logic      out_busy;
    logic [BAND_W-1:0] band_w;
    logic [1:0]        status_w;

    // output word register
    logic              m_valid_reg;
    logic [BAND_W-1:0] m_band_reg;
    logic [1:0]        m_status_reg;

    assign s_ready   = !busy;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_busy  = m_valid_reg && !m_ready;

    vbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    vbc_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_fire       (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_opcode      (s_opcode),
        .in_value       (s_value),
        .in_entry_index (s_entry_index),
        .cmd            (cmd),
        .stat           (stat),
        .band           (band_w),
        .status         (status_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_band_reg   <= band_w;
            m_status_reg <= status_w;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_band   = m_band_reg;
    assign m_status = m_status_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_band) && $stable(m_status))
        else $error("held word changed");
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("second word taken while busy");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("bad status code");

endmodule
